>>> hw/rtl/pvm_pkg.sv
// Shared types, codes and constants of the positional voice mixer.
package pvm_pkg;

  localparam int DEF_VOICE_COUNT   = 64;
  localparam int DEF_CHANNEL_COUNT = 16;
  localparam int DEF_SLOT_COUNT    = 512;
  localparam int DEF_STORE_WORDS   = 65536;

  localparam logic [2:0] FN_WRITE = 3'd0;
  localparam logic [2:0] FN_DESC  = 3'd1;
  localparam logic [2:0] FN_CHAN  = 3'd2;
  localparam logic [2:0] FN_PLAY  = 3'd3;
  localparam logic [2:0] FN_STOP  = 3'd4;
  localparam logic [2:0] FN_MIX   = 3'd5;

  localparam logic REG_LISTENER_X = 1'b0;
  localparam logic REG_LISTENER_Y = 1'b1;

  localparam int FALL_RANGE  = 1500;
  localparam int OUT_LIMIT   = 32767;
  localparam int FULL_GAIN   = 255;
  // ceil(2^32 / 1500): exact floor quotient for every dividend below 2^22
  localparam int RECIP_SHIFT = 32;
  localparam longint RECIP_RANGE = 64'd2863312;

  typedef enum logic [2:0] {
    OP_WRITE, OP_DESC, OP_CHAN, OP_PLAY, OP_STOP, OP_MIX, OP_NONE
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [15:0]       mem_addr;
    logic [15:0]       mem_word;
    logic [8:0]        slot;
    logic [16:0]       frame_count;
    logic [3:0]        channel;
    logic [7:0]        volume;
    logic              flag;
    logic [15:0]       pos_x;
    logic [15:0]       pos_y;
    logic [5:0]        voice;
  } cmd_t;

  typedef struct packed {
    logic [15:0] base;
    logic [16:0] frames;
    logic        stereo;
  } desc_t;

  // floor(x / 1500) for a gain product below 1500 * 256
  function automatic logic [7:0] div_range(input logic [18:0] x);
    logic [63:0] p;
    p = 64'(x) * RECIP_RANGE;
    return p[RECIP_SHIFT+7:RECIP_SHIFT];
  endfunction

endpackage

>>> hw/rtl/pvm_if.sv
// Channel interfaces: command words in, result words out, register writes.
interface pvm_cmd_if;
  logic        valid;
  logic        ready;
  logic [2:0]  func;
  logic [15:0] mem_addr;
  logic [15:0] mem_word;
  logic [8:0]  slot;
  logic [16:0] frame_count;
  logic [3:0]  channel;
  logic [7:0]  volume;
  logic        flag;
  logic [15:0] pos_x;
  logic [15:0] pos_y;
  logic [5:0]  voice;
  modport source (output valid, func, mem_addr, mem_word, slot, frame_count, channel,
                  volume, flag, pos_x, pos_y, voice, input ready);
  modport sink (input valid, func, mem_addr, mem_word, slot, frame_count, channel,
                volume, flag, pos_x, pos_y, voice, output ready);
endinterface

interface pvm_res_if;
  logic        valid;
  logic        ready;
  logic [5:0]  voice_id;
  logic        status;
  logic [15:0] left;
  logic [15:0] right;
  modport source (output valid, voice_id, status, left, right, input ready);
  modport sink (input valid, voice_id, status, left, right, output ready);
endinterface

interface pvm_cfg_if;
  logic        valid;
  logic        ready;
  logic        index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> hw/rtl/pvm_front.sv
// Command front end: accept, decode and queue command words.
module pvm_front import pvm_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      hold,
  pvm_cmd_if.sink   cmd,
  output logic      q_valid,
  output cmd_t      q_cmd,
  input  logic      q_ready
);

  cmd_t       entry [2];
  cmd_t       word_in;
  logic       wp, rp;
  logic [1:0] cnt;
  logic       push, pop;

  always_comb begin
    word_in.mem_addr    = cmd.mem_addr;
    word_in.mem_word    = cmd.mem_word;
    word_in.slot        = cmd.slot;
    word_in.frame_count = cmd.frame_count;
    word_in.channel     = cmd.channel;
    word_in.volume      = cmd.volume;
    word_in.flag        = cmd.flag;
    word_in.pos_x       = cmd.pos_x;
    word_in.pos_y       = cmd.pos_y;
    word_in.voice       = cmd.voice;
    unique case (cmd.func)
      FN_WRITE: word_in.op = OP_WRITE;
      FN_DESC:  word_in.op = OP_DESC;
      FN_CHAN:  word_in.op = OP_CHAN;
      FN_PLAY:  word_in.op = OP_PLAY;
      FN_STOP:  word_in.op = OP_STOP;
      FN_MIX:   word_in.op = OP_MIX;
      default:  word_in.op = OP_NONE;
    endcase
  end

  assign cmd.ready = (cnt != 2'd2) && !hold;
  assign push      = cmd.valid && cmd.ready;
  assign q_valid   = (cnt != 2'd0);
  assign q_cmd     = entry[rp];
  assign pop       = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) begin
        entry[wp] <= word_in;
        wp        <= ~wp;
      end
      if (pop) rp <= ~rp;
      cnt <= cnt + 2'(push) - 2'(pop);
    end
  end

endmodule

>>> hw/rtl/pvm_engine.sv
// Command engine: tables, sample memory, voice walk and result register.
module pvm_engine import pvm_pkg::*; #(
  parameter int VOICE_COUNT   = DEF_VOICE_COUNT,
  parameter int CHANNEL_COUNT = DEF_CHANNEL_COUNT,
  parameter int SLOT_COUNT    = DEF_SLOT_COUNT,
  parameter int STORE_WORDS   = DEF_STORE_WORDS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  input  cmd_t        q_cmd,
  output logic        q_ready,
  input  logic [15:0] listener_x,
  input  logic [15:0] listener_y,
  output logic        clearing,
  pvm_res_if.source   res
);

  localparam int VI_W  = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
  localparam int VC_W  = $clog2(VOICE_COUNT + 1);
  localparam int SL_W  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CH_W  = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
  localparam int ST_W  = $clog2(STORE_WORDS);
  localparam int AD_W  = ((ST_W > 18) ? ST_W : 18) + 1;
  localparam int ACC_W = 25 + $clog2(VOICE_COUNT + 1);

  typedef struct packed {
    logic [SL_W-1:0] slot;
    logic [CH_W-1:0] chan;
    logic [16:0]     tick;
    logic            positional;
    logic [15:0]     x;
    logic [15:0]     y;
  } voice_t;

  typedef enum logic [23:0] {
    ST_CLEAR = 24'b1 << 0,  ST_IDLE = 24'b1 << 1,  ST_WWRAP = 24'b1 << 2,
    ST_PMOD  = 24'b1 << 3,  ST_PSCAN = 24'b1 << 4, ST_VREQ = 24'b1 << 5,
    ST_DREQ  = 24'b1 << 6,  ST_CHK  = 24'b1 << 7,  ST_AWRAP = 24'b1 << 8,
    ST_SL    = 24'b1 << 9,  ST_SR   = 24'b1 << 10, ST_SQX = 24'b1 << 11,
    ST_SQY   = 24'b1 << 12, ST_ROOT = 24'b1 << 13, ST_GPAN = 24'b1 << 14,
    ST_GPDIV = 24'b1 << 15, ST_GLM  = 24'b1 << 16, ST_GLD = 24'b1 << 17,
    ST_GRM   = 24'b1 << 18, ST_GRD  = 24'b1 << 19, ST_MACL = 24'b1 << 20,
    ST_MACR  = 24'b1 << 21, ST_DONE = 24'b1 << 22, ST_RESP = 24'b1 << 23
  } state_t;

  state_t state;

  // memories
  logic [15:0] smem [STORE_WORDS];
  desc_t       dmem [SLOT_COUNT];
  voice_t      vmem [VOICE_COUNT];

  logic            s_we, s_re;
  logic [ST_W-1:0] s_waddr, s_raddr;
  logic [15:0]     s_rdata;
  logic            d_we, d_re;
  logic [SL_W-1:0] d_waddr, d_raddr;
  desc_t           d_wdata, d_rdata;
  logic            v_we, v_re;
  voice_t          v_wdata, v_rdata;

  // control and datapath registers
  logic [VOICE_COUNT-1:0] active;
  logic [7:0]             ch_vol [CHANNEL_COUNT];
  logic                   ch_pan [CHANNEL_COUNT];
  logic [SL_W-1:0]        clr_cnt;
  logic [VC_W-1:0]        vidx;
  logic [VI_W-1:0]        vi;
  cmd_t                   cur;
  voice_t                 cur_v;
  desc_t                  cur_d;
  logic [8:0]             ps;
  logic [3:0]             pc;
  logic [AD_W-1:0]        addr;
  logic [AD_W-1:0]        addr_p1;
  logic                   addr_hi;
  logic signed [15:0]     sl, sr;
  logic [7:0]             lv, rv;
  logic                   pos_on;
  logic signed [16:0]     dx, dy;
  logic [33:0]            sqn, root, rbit;
  logic [16:0]            radius;
  logic [18:0]            prod;
  logic signed [ACC_W-1:0] acc_l, acc_r;
  logic [5:0]             rid;
  logic                   rstat;
  logic [15:0]            rl, rr;
  logic                   ovalid;
  logic [5:0]             o_id;
  logic                   o_stat;
  logic [15:0]            o_l, o_r;

  // shared arithmetic units
  logic signed [16:0]     sq_op;
  logic signed [33:0]     sq_term;
  logic [16:0]            pabs;
  logic [10:0]            g_a;
  logic [7:0]             g_b;
  logic [18:0]            g_p;
  logic signed [15:0]     mac_s;
  logic signed [8:0]      mac_g;
  logic signed [24:0]     mac_p;
  logic [16:0]            tick_inc;

  function automatic logic [15:0] clamp(input logic signed [ACC_W-1:0] a);
    logic signed [ACC_W-1:0] s;
    s = a >>> 8;
    if (s > ACC_W'(OUT_LIMIT)) return 16'(OUT_LIMIT);
    if (s < ACC_W'(-OUT_LIMIT)) return 16'(-OUT_LIMIT);
    return 16'(s);
  endfunction

  assign vi       = VI_W'(vidx);
  assign addr_hi  = 32'(addr) >= STORE_WORDS;
  assign addr_p1  = (32'(addr) + 1 == STORE_WORDS) ? AD_W'(0) : addr + AD_W'(1);
  assign sq_op    = (state == ST_SQY) ? dy : dx;
  assign sq_term  = sq_op * sq_op;
  assign pabs     = dx[16] ? 17'(-dx) : 17'(dx);
  assign g_a      = (state == ST_GPAN) ? 11'(FALL_RANGE) - 11'(pabs)
                                       : 11'(FALL_RANGE) - 11'(radius);
  assign g_b      = (state == ST_GRM) ? rv : lv;
  assign g_p      = g_a * g_b;
  assign mac_s    = (state == ST_MACR) ? sr : sl;
  assign mac_g    = $signed({1'b0, ((state == ST_MACR) ? rv : lv)});
  assign mac_p    = mac_s * mac_g;
  assign tick_inc = cur_v.tick + 17'd1;

  assign clearing = (state == ST_CLEAR);
  assign q_ready  = (state == ST_IDLE);

  // memory port control
  always_comb begin
    s_we    = (state == ST_WWRAP) && !addr_hi;
    s_waddr = ST_W'(addr);
    s_re    = ((state == ST_AWRAP) && !addr_hi) || ((state == ST_SL) && cur_d.stereo);
    s_raddr = (state == ST_SL) ? ST_W'(addr_p1) : ST_W'(addr);

    d_we    = clearing || (q_valid && q_ready && (q_cmd.op == OP_DESC)
                           && (32'(q_cmd.slot) < SLOT_COUNT));
    d_waddr = clearing ? clr_cnt : SL_W'(q_cmd.slot);
    d_wdata = clearing ? '0 : desc_t'{q_cmd.mem_addr, q_cmd.frame_count, q_cmd.flag};
    d_re    = (state == ST_DREQ);
    d_raddr = v_rdata.slot;

    v_re    = (state == ST_VREQ) && (32'(vidx) < VOICE_COUNT) && active[vi];
    v_we    = ((state == ST_PSCAN) && (32'(vidx) < VOICE_COUNT) && !active[vi])
              || (state == ST_MACR);
    if (state == ST_MACR) begin
      v_wdata      = cur_v;
      v_wdata.tick = tick_inc;
    end else begin
      v_wdata = voice_t'{SL_W'(ps), CH_W'(pc), 17'd0, cur.flag, cur.pos_x, cur.pos_y};
    end
  end

  always_ff @(posedge clk) begin
    if (s_we) smem[s_waddr] <= cur.mem_word;
    if (s_re) s_rdata <= smem[s_raddr];
  end

  always_ff @(posedge clk) begin
    if (d_we) dmem[d_waddr] <= d_wdata;
    if (d_re) d_rdata <= dmem[d_raddr];
  end

  always_ff @(posedge clk) begin
    if (v_we) vmem[vi] <= v_wdata;
    if (v_re) v_rdata <= vmem[vi];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_cnt <= '0;
      active  <= '0;
      ovalid  <= 1'b0;
      for (int i = 0; i < CHANNEL_COUNT; i++) begin
        ch_vol[i] <= (i == 0) ? 8'(FULL_GAIN) : 8'd0;
        ch_pan[i] <= 1'b0;
      end
    end else begin
      if (res.valid && res.ready && (state != ST_RESP)) ovalid <= 1'b0;
      unique case (state)
        ST_CLEAR: begin
          clr_cnt <= clr_cnt + SL_W'(1);
          if (clr_cnt == SL_W'(SLOT_COUNT - 1)) state <= ST_IDLE;
        end
        ST_IDLE: begin
          if (q_valid) begin
            cur   <= q_cmd;
            rid   <= 6'd0;
            rstat <= 1'b0;
            rl    <= 16'd0;
            rr    <= 16'd0;
            unique case (q_cmd.op)
              OP_WRITE: begin
                addr  <= AD_W'(q_cmd.mem_addr);
                state <= ST_WWRAP;
              end
              OP_CHAN: begin
                if (32'(q_cmd.channel) < CHANNEL_COUNT) begin
                  ch_vol[CH_W'(q_cmd.channel)] <= q_cmd.volume;
                  ch_pan[CH_W'(q_cmd.channel)] <= q_cmd.flag;
                end
                state <= ST_RESP;
              end
              OP_PLAY: begin
                ps    <= q_cmd.slot;
                pc    <= q_cmd.channel;
                vidx  <= '0;
                state <= ST_PMOD;
              end
              OP_STOP: begin
                if (32'(q_cmd.voice) < VOICE_COUNT) active[VI_W'(q_cmd.voice)] <= 1'b0;
                state <= ST_RESP;
              end
              OP_MIX: begin
                vidx  <= '0;
                acc_l <= '0;
                acc_r <= '0;
                state <= ST_VREQ;
              end
              default: state <= ST_RESP;
            endcase
          end
        end
        ST_WWRAP: begin
          if (addr_hi) addr <= addr - AD_W'(STORE_WORDS);
          else state <= ST_RESP;
        end
        ST_PMOD: begin
          // reduce slot and channel one subtraction at a time
          if (32'(ps) >= SLOT_COUNT) ps <= ps - 9'(SLOT_COUNT);
          else if (32'(pc) >= CHANNEL_COUNT) pc <= pc - 4'(CHANNEL_COUNT);
          else state <= ST_PSCAN;
        end
        ST_PSCAN: begin
          if (32'(vidx) == VOICE_COUNT) begin
            rstat <= 1'b1;
            state <= ST_RESP;
          end else if (!active[vi]) begin
            active[vi] <= 1'b1;
            rid        <= 6'(vidx);
            state      <= ST_RESP;
          end else begin
            vidx <= vidx + VC_W'(1);
          end
        end
        ST_VREQ: begin
          if (32'(vidx) == VOICE_COUNT) state <= ST_DONE;
          else if (active[vi]) state <= ST_DREQ;
          else vidx <= vidx + VC_W'(1);
        end
        ST_DREQ: begin
          cur_v <= v_rdata;
          state <= ST_CHK;
        end
        ST_CHK: begin
          cur_d <= d_rdata;
          if (cur_v.tick >= d_rdata.frames) begin
            active[vi] <= 1'b0;
            vidx       <= vidx + VC_W'(1);
            state      <= ST_VREQ;
          end else begin
            addr   <= AD_W'(d_rdata.base) +
                      (d_rdata.stereo ? AD_W'({cur_v.tick, 1'b0}) : AD_W'(cur_v.tick));
            lv     <= ch_vol[cur_v.chan];
            rv     <= ch_vol[cur_v.chan];
            pos_on <= cur_v.positional && ch_pan[cur_v.chan];
            dx     <= $signed({cur_v.x[15], cur_v.x}) - $signed({listener_x[15], listener_x});
            dy     <= $signed({cur_v.y[15], cur_v.y}) - $signed({listener_y[15], listener_y});
            state  <= ST_AWRAP;
          end
        end
        ST_AWRAP: begin
          if (addr_hi) addr <= addr - AD_W'(STORE_WORDS);
          else state <= ST_SL;
        end
        ST_SL: begin
          sl <= s_rdata;
          sr <= s_rdata;
          if (cur_d.stereo) state <= ST_SR;
          else state <= pos_on ? ST_SQX : ST_MACL;
        end
        ST_SR: begin
          sr    <= s_rdata;
          state <= pos_on ? ST_SQX : ST_MACL;
        end
        ST_SQX: begin
          sqn   <= 34'(sq_term);
          state <= ST_SQY;
        end
        ST_SQY: begin
          sqn   <= sqn + 34'(sq_term);
          root  <= '0;
          rbit  <= 34'd1 << 32;
          state <= ST_ROOT;
        end
        ST_ROOT: begin
          // one restoring square-root step per cycle
          if (rbit == '0) begin
            radius <= 17'(root);
            state  <= ST_GPAN;
          end else begin
            if (sqn >= root + rbit) begin
              sqn  <= sqn - (root + rbit);
              root <= (root >> 1) + rbit;
            end else begin
              root <= root >> 1;
            end
            rbit <= rbit >> 2;
          end
        end
        ST_GPAN: begin
          if (radius >= 17'(FALL_RANGE)) begin
            state <= ST_MACL;
          end else begin
            prod  <= g_p;
            state <= ST_GPDIV;
          end
        end
        ST_GPDIV: begin
          if (!dx[16] && (dx != '0)) lv <= div_range(prod);
          else rv <= div_range(prod);
          state <= ST_GLM;
        end
        ST_GLM: begin
          prod  <= g_p;
          state <= ST_GLD;
        end
        ST_GLD: begin
          lv    <= div_range(prod);
          state <= ST_GRM;
        end
        ST_GRM: begin
          prod  <= g_p;
          state <= ST_GRD;
        end
        ST_GRD: begin
          rv    <= div_range(prod);
          state <= ST_MACL;
        end
        ST_MACL: begin
          acc_l <= acc_l + ACC_W'(mac_p);
          state <= ST_MACR;
        end
        ST_MACR: begin
          acc_r <= acc_r + ACC_W'(mac_p);
          if (tick_inc >= cur_d.frames) active[vi] <= 1'b0;
          vidx  <= vidx + VC_W'(1);
          state <= ST_VREQ;
        end
        ST_DONE: begin
          rl    <= clamp(acc_l);
          rr    <= clamp(acc_r);
          state <= ST_RESP;
        end
        ST_RESP: begin
          if (!ovalid || res.ready) begin
            ovalid <= 1'b1;
            o_id   <= rid;
            o_stat <= rstat;
            o_l    <= rl;
            o_r    <= rr;
            state  <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign res.valid    = ovalid;
  assign res.voice_id = o_id;
  assign res.status   = o_stat;
  assign res.left     = o_l;
  assign res.right    = o_r;

endmodule

>>> hw/rtl/positional_voice_mixer.sv
// Top level of the positional voice mixer: front end, engine and listener registers.
//
// Each command word writes a sample word, sets a sample descriptor or a channel
// (gain and pan enable), starts a voice in the lowest free slot, stops a voice,
// or mixes one stereo frame, and any other func code does nothing; every word
// yields exactly one result word. After reset the engine sweeps the descriptor
// memory to zero, one entry a cycle; command words wait during that sweep,
// register writes do not. A two-word queue sits between the front end and the
// engine, and the result sits in an output register, so commands keep flowing in
// while a result waits to be taken. The engine handles one command at a time. A
// sample write steps its address back into the store once per wrap, and a play
// scans the voices after reducing slot and channel by modulo steps. A mix frame
// walks every voice slot through a single sample memory port: it skips an idle
// voice, frees a voice that has run out, reads one sample word (two for stereo)
// for an active voice, and for a positional voice on a pan-enabled channel adds
// a restoring square root and the gain multiply/divide steps, which dominate;
// each sample address that runs past the store is wrapped back into it.
module positional_voice_mixer import pvm_pkg::*; #(
  parameter int VOICE_COUNT   = DEF_VOICE_COUNT,
  parameter int CHANNEL_COUNT = DEF_CHANNEL_COUNT,
  parameter int SLOT_COUNT    = DEF_SLOT_COUNT,
  parameter int STORE_WORDS   = DEF_STORE_WORDS
) (
  input  logic      clk,
  input  logic      rst,
  pvm_cmd_if.sink   cmd,
  pvm_res_if.source res,
  pvm_cfg_if.sink   cfg
);

  logic        q_valid;
  logic        q_ready;
  cmd_t        q_cmd;
  logic        clearing;
  logic [15:0] listener_x;
  logic [15:0] listener_y;

  // listener position: always ready; to be written only while the block is quiet, which the block does not enforce
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      listener_x <= 16'd0;
      listener_y <= 16'd0;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        REG_LISTENER_X: listener_x <= cfg.data;
        REG_LISTENER_Y: listener_y <= cfg.data;
        default: ;
      endcase
    end
  end

  // accept, decode and hold up to two command words
  pvm_front u_front (
    .clk     (clk),
    .rst     (rst),
    .hold    (clearing),
    .cmd     (cmd),
    .q_valid (q_valid),
    .q_cmd   (q_cmd),
    .q_ready (q_ready)
  );

  // execute one command word at a time and register its result
  pvm_engine #(
    .VOICE_COUNT   (VOICE_COUNT),
    .CHANNEL_COUNT (CHANNEL_COUNT),
    .SLOT_COUNT    (SLOT_COUNT),
    .STORE_WORDS   (STORE_WORDS)
  ) u_engine (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_cmd      (q_cmd),
    .q_ready    (q_ready),
    .listener_x (listener_x),
    .listener_y (listener_y),
    .clearing   (clearing),
    .res        (res)
  );

  // a failed play carries no voice and no audio
  assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.status) |-> (res.voice_id == 6'd0 && res.left == 16'd0
                                   && res.right == 16'd0))
    else $error("failed play result carries payload");

  // a result with a nonzero voice id carries no audio
  assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.voice_id != 6'd0) |-> (res.left == 16'd0 && res.right == 16'd0))
    else $error("voice id and audio in one result");

  // the clamp never lets the most negative code out
  assert property (@(posedge clk) disable iff (rst)
    res.valid |-> (res.left != 16'h8000 && res.right != 16'h8000))
    else $error("mix output outside clamp range");

endmodule

>>> tb/sv/positional_voice_mixer_tb.sv
// Self-checking testbench of the positional voice mixer: directed rows, then random traffic.
module positional_voice_mixer_tb;
  import pvm_pkg::*;

  // Codes the package leaves unnamed: the last spare func and the play status.
  localparam logic [2:0] FN_SPARE  = 3'd7;
  localparam logic       ST_OK     = 1'b0;
  localparam logic       ST_FULL   = 1'b1;

  // Every sample read stays inside this window, written in full before any mix,
  // so no word that was never written is ever read back.
  localparam int        WIN_LEN    = 256;
  localparam bit [15:0] WIN_BASE   = 16'hffe0;
  localparam int        PHASE_LEN  = 370;
  localparam int        CYCLE_CAP  = 30000000;

  typedef struct {
    bit [2:0]  func;
    bit [15:0] mem_addr;
    bit [15:0] mem_word;
    bit [8:0]  slot;
    bit [16:0] frame_count;
    bit [3:0]  channel;
    bit [7:0]  volume;
    bit        flag;
    bit [15:0] pos_x;
    bit [15:0] pos_y;
    bit [5:0]  voice;
  } mix_word_t;

  typedef struct {
    bit [5:0]  voice_id;
    bit        status;
    bit [15:0] left;
    bit [15:0] right;
  } mix_out_t;

  typedef struct {
    mix_word_t w;
    bit        typed;
    mix_out_t  want;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  pvm_cmd_if cmd_ch ();
  pvm_res_if res_ch ();
  pvm_cfg_if cfg_ch ();

  positional_voice_mixer DUT (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch.sink),
    .res (res_ch.source),
    .cfg (cfg_ch.sink)
  );

  always #1 clk = ~clk;

  // Shadow state of the mixer.
  bit [15:0] words [0:65535];
  bit [15:0] d_base [0:511];
  bit [16:0] d_frames [0:511];
  bit        d_stereo [0:511];
  bit [7:0]  ch_vol [0:15];
  bit        ch_pan [0:15];
  bit        v_on [0:63];
  int        v_slot [0:63];
  int        v_chan [0:63];
  int        v_tick [0:63];
  bit        v_pos [0:63];
  int        v_x [0:63];
  int        v_y [0:63];
  int        lis_x;
  int        lis_y;

  mix_out_t  pending_out [$];
  int        errors = 0;
  int        n_words;
  int        n_mix;
  int        n_loud;
  int        n_full;
  int        n_results = 0;
  bit        choke_req;
  int        cycles = 0;

  function automatic longint unsigned root_floor(longint unsigned n);
    longint unsigned lo, hi, mid;
    lo = 0;
    hi = 64'd4294967296;
    while (hi - lo > 1) begin
      mid = (lo + hi) / 2;
      if (mid * mid <= n) lo = mid;
      else hi = mid;
    end
    return lo;
  endfunction

  function automatic bit [15:0] clamp_out(longint acc);
    longint v;
    v = acc >>> 8;
    if (v > OUT_LIMIT) v = OUT_LIMIT;
    if (v < -OUT_LIMIT) v = -OUT_LIMIT;
    return 16'(v);
  endfunction

  function automatic void reset_shadow();
    for (int i = 0; i < 512; i++) begin
      d_base[i] = '0; d_frames[i] = '0; d_stereo[i] = 1'b0;
    end
    for (int i = 0; i < 16; i++) begin
      ch_vol[i] = '0; ch_pan[i] = 1'b0;
    end
    ch_vol[0] = 8'(FULL_GAIN);
    for (int i = 0; i < 64; i++) v_on[i] = 1'b0;
    lis_x = 0;
    lis_y = 0;
  endfunction

  // Sum one frame over all voices, advancing and freeing them as it goes.
  function automatic mix_out_t mix_once();
    mix_out_t  r;
    longint    accl, accr, lv, rv, dx, dy, p, radius;
    int        s, step;
    bit [15:0] a;
    longint    sl, sr;
    accl = 0;
    accr = 0;
    r = '{default: 0};
    for (int i = 0; i < 64; i++) begin
      if (!v_on[i]) continue;
      s = v_slot[i];
      if (v_tick[i] >= int'(d_frames[s])) begin
        v_on[i] = 1'b0;
        continue;
      end
      step = d_stereo[s] ? 2 : 1;
      a = 16'(int'(d_base[s]) + v_tick[i] * step);
      sl = longint'($signed(words[a]));
      sr = d_stereo[s] ? longint'($signed(words[16'(a + 1)])) : sl;
      lv = ch_vol[v_chan[i]];
      rv = lv;
      if (v_pos[i] && ch_pan[v_chan[i]]) begin
        dx = longint'(v_x[i]) - lis_x;
        dy = longint'(v_y[i]) - lis_y;
        radius = longint'(root_floor(64'(dx * dx + dy * dy)));
        p = dx < 0 ? -dx : dx;
        if (radius < FALL_RANGE) begin
          if (dx > 0) lv = ((FALL_RANGE - p) * lv) / FALL_RANGE;
          else rv = ((FALL_RANGE - p) * rv) / FALL_RANGE;
          lv = (lv * (FALL_RANGE - radius)) / FALL_RANGE;
          rv = (rv * (FALL_RANGE - radius)) / FALL_RANGE;
        end
      end
      accl += sl * lv;
      accr += sr * rv;
      v_tick[i]++;
      if (v_tick[i] >= int'(d_frames[s])) v_on[i] = 1'b0;
    end
    r.left = clamp_out(accl);
    r.right = clamp_out(accr);
    return r;
  endfunction

  // Apply one command word to the shadow state and return its result word.
  function automatic mix_out_t apply_word(mix_word_t w);
    mix_out_t r;
    int       found;
    r = '{default: 0};
    case (w.func)
      FN_WRITE: words[w.mem_addr] = w.mem_word;
      FN_DESC: begin
        d_base[w.slot] = w.mem_addr;
        d_frames[w.slot] = w.frame_count;
        d_stereo[w.slot] = w.flag;
      end
      FN_CHAN: begin
        ch_vol[w.channel] = w.volume;
        ch_pan[w.channel] = w.flag;
      end
      FN_PLAY: begin
        found = -1;
        for (int i = 0; i < 64; i++) if (!v_on[i] && found < 0) found = i;
        if (found < 0) begin
          r.status = ST_FULL;
          n_full++;
        end else begin
          v_on[found] = 1'b1;
          v_slot[found] = w.slot;
          v_chan[found] = w.channel;
          v_tick[found] = 0;
          v_pos[found] = w.flag;
          v_x[found] = int'($signed(w.pos_x));
          v_y[found] = int'($signed(w.pos_y));
          r.voice_id = 6'(found);
        end
      end
      FN_STOP: v_on[w.voice] = 1'b0;
      FN_MIX: begin
        r = mix_once();
        n_mix++;
        if (r.left != 0 || r.right != 0) n_loud++;
      end
      default: ;
    endcase
    return r;
  endfunction

  // Offer one word, hold it until taken, then queue what it should produce.
  task automatic send_word(mix_word_t w, bit typed, mix_out_t want);
    mix_out_t got;
    cmd_ch.valid       <= 1'b1;
    cmd_ch.func        <= w.func;
    cmd_ch.mem_addr    <= w.mem_addr;
    cmd_ch.mem_word    <= w.mem_word;
    cmd_ch.slot        <= w.slot;
    cmd_ch.frame_count <= w.frame_count;
    cmd_ch.channel     <= w.channel;
    cmd_ch.volume      <= w.volume;
    cmd_ch.flag        <= w.flag;
    cmd_ch.pos_x       <= w.pos_x;
    cmd_ch.pos_y       <= w.pos_y;
    cmd_ch.voice       <= w.voice;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    got = apply_word(w);
    pending_out.push_back(typed ? want : got);
    n_words++;
  endtask

  task automatic idle_sender(int gap);
    if (gap > 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Hold off until every result is back, then let the engine settle.
  task automatic drain();
    idle_sender(1);
    while (pending_out.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, bit [15:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    if (idx == REG_LISTENER_X) lis_x = int'($signed(val));
    else lis_y = int'($signed(val));
    @(posedge clk);
  endtask

  function automatic mix_word_t mk(bit [2:0] f, bit [15:0] addr, bit [15:0] wd, bit [8:0] sl,
                                   bit [16:0] fr, bit [3:0] ch, bit [7:0] vol, bit fl,
                                   bit [15:0] px, bit [15:0] py, bit [5:0] vc);
    mix_word_t w;
    w.func = f; w.mem_addr = addr; w.mem_word = wd; w.slot = sl; w.frame_count = fr;
    w.channel = ch; w.volume = vol; w.flag = fl; w.pos_x = px; w.pos_y = py; w.voice = vc;
    return w;
  endfunction

  function automatic mix_out_t out_of(bit [5:0] id, bit st, bit [15:0] l, bit [15:0] r);
    mix_out_t o;
    o.voice_id = id; o.status = st; o.left = l; o.right = r;
    return o;
  endfunction

  // Position close to the listener so the falloff actually bites, or anywhere.
  function automatic bit [15:0] place(int lis);
    if ($urandom_range(1, 0)) return 16'(lis + $urandom_range(3200, 0) - 1600);
    return 16'($urandom);
  endfunction

  // Random word with all fields filled, then shaped for its func.
  function automatic mix_word_t random_word();
    mix_word_t w;
    int        pick, off, room;
    w = mk(3'd0, 16'($urandom), 16'($urandom), 9'($urandom), 17'($urandom), 4'($urandom),
           8'($urandom), 1'($urandom), 16'($urandom), 16'($urandom), 6'($urandom));
    pick = $urandom_range(99, 0);
    if (pick < 10) begin
      w.func = FN_WRITE;
      if (pick < 8) w.mem_addr = WIN_BASE + 16'($urandom_range(WIN_LEN - 1, 0));
    end else if (pick < 20) begin
      w.func = FN_DESC;
      off = $urandom_range(200, 0);
      room = (WIN_LEN - 1 - off - int'(w.flag)) / (w.flag ? 2 : 1);
      if (room > 30) room = 30;
      w.mem_addr = WIN_BASE + 16'(off);
      w.frame_count = 17'($urandom_range(room, 0));
    end else if (pick < 30) begin
      w.func = FN_CHAN;
      if (pick < 22) w.volume = 8'(FULL_GAIN);
      else if (pick < 24) w.volume = 8'd0;
    end else if (pick < 55) begin
      w.func = FN_PLAY;
      w.pos_x = place(lis_x);
      w.pos_y = place(lis_y);
    end else if (pick < 62) begin
      w.func = FN_STOP;
    end else if (pick < 96) begin
      w.func = FN_MIX;
    end else begin
      w.func = pick < 98 ? 3'(OP_NONE) : FN_SPARE;
    end
    return w;
  endfunction

  // Result side: check each word taken and stall on a shifting pattern, with one
  // long hold-off on request so the input side backs up.
  int rx_cyc = 0;
  int choke_left = 0;
  bit choke_done = 1'b0;
  mix_out_t head;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && res_ch.valid && res_ch.ready) begin
      n_results++;
      if (pending_out.size() == 0) begin
        $display("%0t: result with nothing pending: id %0d st %0d l %0d r %0d", $time,
                 res_ch.voice_id, res_ch.status, $signed(res_ch.left), $signed(res_ch.right));
        errors++;
      end else begin
        head = pending_out.pop_front();
        if (head.voice_id != res_ch.voice_id || head.status != res_ch.status ||
            head.left != res_ch.left || head.right != res_ch.right) begin
          $display("%0t: mismatch expected id %0d st %0d l %0d r %0d, got id %0d st %0d l %0d r %0d",
                   $time, head.voice_id, head.status, $signed(head.left), $signed(head.right),
                   res_ch.voice_id, res_ch.status, $signed(res_ch.left), $signed(res_ch.right));
          errors++;
        end
      end
    end
    rx_cyc++;
    if (choke_left > 0) begin
      choke_left--;
      res_ch.ready <= 1'b0;
    end else if (choke_req && !choke_done) begin
      choke_done = 1'b1;
      choke_left = 600;
      res_ch.ready <= 1'b0;
    end else begin
      case ((rx_cyc / 300) % 3)
        0: res_ch.ready <= 1'b1;
        1: res_ch.ready <= 1'($urandom);
        default: res_ch.ready <= ($urandom_range(7, 0) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (cycles > CYCLE_CAP) begin
      $display("timeout after %0d cycles, %0d results pending", cycles, pending_out.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  row_t rows [0:24];
  int   burst;
  int   phase_x [0:3] = '{0, 32767, -32768, 0};
  int   phase_y [0:3] = '{0, -32768, 32767, 0};

  initial begin
    mix_word_t w;
    n_words = 0; n_mix = 0; n_loud = 0; n_full = 0;
    choke_req = 1'b0;
    cmd_ch.valid = 1'b0;
    cmd_ch.func = FN_WRITE; cmd_ch.mem_addr = '0; cmd_ch.mem_word = '0; cmd_ch.slot = '0;
    cmd_ch.frame_count = '0; cmd_ch.channel = '0; cmd_ch.volume = '0; cmd_ch.flag = 1'b0;
    cmd_ch.pos_x = '0; cmd_ch.pos_y = '0; cmd_ch.voice = '0;
    cfg_ch.valid = 1'b0; cfg_ch.index = REG_LISTENER_X; cfg_ch.data = '0;
    reset_shadow();

    // Directed rows; typed results where they follow at a glance.
    rows[0]  = '{mk(FN_MIX, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, out_of(0, ST_OK, 0, 0)};
    rows[1]  = '{mk(3'(OP_NONE), 16'hffff, 16'hffff, 9'h1ff, 17'h1ffff, 4'hf, 8'hff, 1,
                    16'hffff, 16'hffff, 6'h3f), 1, out_of(0, ST_OK, 0, 0)};
    rows[2]  = '{mk(FN_SPARE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, out_of(0, ST_OK, 0, 0)};
    rows[3]  = '{mk(FN_WRITE, 0, 16'h7fff, 0, 0, 0, 0, 0, 0, 0, 0), 1, out_of(0, ST_OK, 0, 0)};
    rows[4]  = '{mk(FN_WRITE, 1, 16'h8000, 0, 0, 0, 0, 0, 0, 0, 0), 1, out_of(0, ST_OK, 0, 0)};
    rows[5]  = '{mk(FN_DESC, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0), 1, out_of(0, ST_OK, 0, 0)};
    rows[6]  = '{mk(FN_DESC, 1, 0, 1, 1, 0, 0, 0, 0, 0, 0), 1, out_of(0, ST_OK, 0, 0)};
    rows[7]  = '{mk(FN_PLAY, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, out_of(0, ST_OK, 0, 0)};
    rows[8]  = '{mk(FN_MIX, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1,
                 out_of(0, ST_OK, 16'sd32639, 16'sd32639)};
    rows[9]  = '{mk(FN_PLAY, 0, 0, 1, 0, 0, 0, 0, 0, 0, 0), 1, out_of(0, ST_OK, 0, 0)};
    rows[10] = '{mk(FN_MIX, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1,
                 out_of(0, ST_OK, -16'sd32640, -16'sd32640)};
    rows[11] = '{mk(FN_PLAY, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, out_of(0, ST_OK, 0, 0)};
    rows[12] = '{mk(FN_PLAY, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, out_of(1, ST_OK, 0, 0)};
    rows[13] = '{mk(FN_PLAY, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, out_of(2, ST_OK, 0, 0)};
    rows[14] = '{mk(FN_MIX, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1,
                 out_of(0, ST_OK, 16'sd32767, 16'sd32767)};
    rows[15] = '{mk(FN_PLAY, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, out_of(0, ST_OK, 0, 0)};
    rows[16] = '{mk(FN_STOP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, out_of(0, ST_OK, 0, 0)};
    rows[17] = '{mk(FN_MIX, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, out_of(0, ST_OK, 0, 0)};
    // Largest sample, then rewritten before any mix so no word past the window is read.
    rows[18] = '{mk(FN_DESC, 16'hffff, 0, 9'd511, 17'd65536, 0, 0, 1, 0, 0, 0), 1,
                 out_of(0, ST_OK, 0, 0)};
    rows[19] = '{mk(FN_DESC, 16'hffff, 0, 9'd511, 17'd1, 0, 0, 1, 0, 0, 0), 1,
                 out_of(0, ST_OK, 0, 0)};
    rows[20] = '{mk(FN_CHAN, 0, 0, 0, 0, 4'd15, 8'd255, 1, 0, 0, 0), 1, out_of(0, ST_OK, 0, 0)};
    // Stereo frame wrapping the store, positional and near the listener.
    rows[21] = '{mk(FN_PLAY, 0, 0, 9'd511, 0, 4'd15, 0, 1, 16'd700, 16'hfe0c, 0), 0, '{default: 0}};
    rows[22] = '{mk(FN_PLAY, 0, 0, 9'd511, 0, 4'd15, 0, 1, 16'hfc18, 16'd10, 0), 0, '{default: 0}};
    rows[23] = '{mk(FN_MIX, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, '{default: 0}};
    rows[24] = '{mk(FN_CHAN, 0, 0, 0, 0, 4'd15, 8'd0, 0, 0, 0, 0), 1, out_of(0, ST_OK, 0, 0)};

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Fill the sample window, which wraps through the top of the store.
    for (int k = 0; k < WIN_LEN; k++) begin
      w = mk(FN_WRITE, WIN_BASE + 16'(k), 16'($urandom), 0, 0, 0, 0, 0, 0, 0, 0);
      send_word(w, 1'b0, '{default: 0});
    end
    foreach (rows[i]) begin
      send_word(rows[i].w, rows[i].typed, rows[i].want);
      idle_sender($urandom_range(2, 0));
    end

    // Fill every voice with a long sample so a play finds none free.
    send_word(mk(FN_DESC, WIN_BASE, 0, 9'd2, 17'd200, 0, 0, 0, 0, 0, 0), 1'b0, '{default: 0});
    for (int k = 0; k < 66; k++) send_word(mk(FN_PLAY, 0, 0, 9'd2, 0, 0, 0, 0, 0, 0, 0),
                                           1'b0, '{default: 0});
    repeat (2) send_word(mk(FN_MIX, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, '{default: 0});
    for (int k = 0; k < 64; k++) send_word(mk(FN_STOP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 6'(k)),
                                           1'b0, '{default: 0});
    drain();

    // Random phases, one listener setting each: the origin, both extremes, then a random spot.
    for (int ph = 0; ph < 4; ph++) begin
      if (ph == 3) begin
        phase_x[ph] = int'($signed(16'($urandom)));
        phase_y[ph] = int'($signed(16'($urandom)));
      end
      write_reg(REG_LISTENER_X, 16'(phase_x[ph]));
      write_reg(REG_LISTENER_Y, 16'(phase_y[ph]));
      if (ph == 1) choke_req <= 1'b1;
      for (int n = 0; n < PHASE_LEN; n += burst) begin
        burst = $urandom_range(20, 1);
        for (int b = 0; b < burst; b++) send_word(random_word(), 1'b0, '{default: 0});
        idle_sender($urandom_range(4, 0) == 0 ? 0 : $urandom_range(8, 1));
      end
      drain();
    end

    $display("%0d words sent, %0d results checked: %0d mixes (%0d nonzero), %0d plays refused",
             n_words, n_results, n_mix, n_loud, n_full);
    $display("listener swept through both extremes and a random spot; %0d errors", errors);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
